// ----- hw/rtl/stt_pkg.sv -----
// stt_pkg: shared types, token kind codes, character classes and the keyword
// table for the source text tokenizer.
// No dependencies; imported by every module in hw/rtl.
`timescale 1ns / 1ps

package stt_pkg;

    // Token kind codes
    localparam logic [3:0] K_INT     = 4'd0;
    localparam logic [3:0] K_STR_KW  = 4'd1;
    localparam logic [3:0] K_IF      = 4'd2;
    localparam logic [3:0] K_ELSE    = 4'd3;
    localparam logic [3:0] K_FOR     = 4'd4;
    localparam logic [3:0] K_DO      = 4'd5;
    localparam logic [3:0] K_WHILE   = 4'd6;
    localparam logic [3:0] K_RETURN  = 4'd7;
    localparam logic [3:0] K_IDENT   = 4'd8;
    localparam logic [3:0] K_NUMBER  = 4'd9;
    localparam logic [3:0] K_FLOAT   = 4'd10;
    localparam logic [3:0] K_STRING  = 4'd11;
    localparam logic [3:0] K_OPER    = 4'd12;
    localparam logic [3:0] K_SEP     = 4'd13;
    localparam logic [3:0] K_UNKNOWN = 4'd14;
    localparam logic [3:0] K_END     = 4'd15;

    // Special characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_EQ    = 8'h3D;

    // Keyword table: identifier bytes packed last byte lowest
    localparam int KW_COUNT = 9;
    localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
        48'h0000_0069_6E74,   // int
        48'h0066_6C6F_6174,   // float (reported as int)
        48'h7374_7269_6E67,   // string
        48'h0000_0000_6966,   // if
        48'h0000_656C_7365,   // else
        48'h0000_0066_6F72,   // for
        48'h0000_0000_646F,   // do
        48'h0077_6869_6C65,   // while
        48'h7265_7475_726E    // return
    };
    localparam logic [3:0] KW_KIND [KW_COUNT] = '{
        K_INT, K_INT, K_STR_KW, K_IF, K_ELSE, K_FOR, K_DO, K_WHILE, K_RETURN
    };

    // One result beat
    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] start;
        logic [15:0] length;
        logic        last;
    } token_t;

    // Results produced by one byte: count (0..2) and up to two tokens
    typedef struct packed {
        logic [1:0] cnt;
        token_t     tok0;
        token_t     tok1;
    } emit_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    // = + - * / % < > !
    function automatic logic is_op(input logic [7:0] c);
        return c == 8'h3D || c == 8'h2B || c == 8'h2D || c == 8'h2A || c == 8'h2F ||
               c == 8'h25 || c == 8'h3C || c == 8'h3E || c == 8'h21;
    endfunction

    // Operators that may take a trailing '=': = ! < >
    function automatic logic is_op_pair(input logic [7:0] c);
        return c == 8'h3D || c == 8'h21 || c == 8'h3C || c == 8'h3E;
    endfunction

    // ( ) ; { } ,
    function automatic logic is_sep(input logic [7:0] c);
        return c == 8'h28 || c == 8'h29 || c == 8'h3B || c == 8'h7B ||
               c == 8'h7D || c == 8'h2C;
    endfunction

endpackage

// ----- hw/rtl/stt_lexer.sv -----
// stt_lexer: scanner state registers and the single-byte step logic that
// classes a byte, closes a pending token and opens a new one.
// Depends on stt_pkg.
`timescale 1ns / 1ps

module stt_lexer #(
    parameter int OFFSET_BITS = 16
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           step,       // consume cur_byte this cycle
    input  logic [7:0]     cur_byte,
    output stt_pkg::emit_t emit        // results of cur_byte, valid with step
);
    import stt_pkg::*;

    localparam logic [2:0] M_IDLE       = 3'd0;
    localparam logic [2:0] M_IDENT      = 3'd1;
    localparam logic [2:0] M_IDENT_LONG = 3'd2;
    localparam logic [2:0] M_NUM        = 3'd3;
    localparam logic [2:0] M_NUM_DOT    = 3'd4;
    localparam logic [2:0] M_STRING     = 3'd5;
    localparam logic [2:0] M_OP         = 3'd6;

    localparam int WB = (OFFSET_BITS > 16) ? OFFSET_BITS : 17;
    localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

    logic [2:0]             mode_reg,  mode_next;
    logic [OFFSET_BITS-1:0] off_reg,   off_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [47:0]            kw_reg,    kw_next;

    logic                   consumed;
    logic                   pend_emit, new_emit;
    token_t                 pend_tok,  new_tok;
    logic [3:0]             kw_kind;
    logic [OFFSET_BITS-1:0] cur_inc;
    logic [15:0]            span_len;

    // Clamp an offset to the 16-bit result field
    function automatic logic [15:0] sat16(input logic [OFFSET_BITS-1:0] v);
        logic [WB-1:0] w;
        w = WB'(v);
        return (w > WB'(17'h0FFFF)) ? 16'hFFFF : w[15:0];
    endfunction

    // Keyword lookup; first table match wins
    always_comb begin
        kw_kind = K_IDENT;
        for (int i = KW_COUNT - 1; i >= 0; i--) begin
            if (KW_TEXT[i] == kw_reg) begin
                kw_kind = KW_KIND[i];
            end
        end
    end

    assign cur_inc  = (off_reg == OFF_MAX) ? off_reg : off_reg + OFFSET_BITS'(1);
    assign span_len = sat16((off_reg >= start_reg) ? off_reg - start_reg : '0);

    // Step logic
    always_comb begin
        mode_next  = mode_reg;
        kw_next    = kw_reg;
        start_next = start_reg;
        off_next   = cur_inc;
        consumed   = 1'b0;
        pend_emit  = 1'b0;
        new_emit   = 1'b0;
        pend_tok   = '{kind: K_IDENT, start: sat16(start_reg), length: span_len, last: 1'b0};
        new_tok    = '{kind: K_UNKNOWN, start: sat16(off_reg), length: 16'd0, last: 1'b0};

        // close or extend the pending token
        case (mode_reg)
            M_IDENT, M_IDENT_LONG: begin
                if (is_alpha(cur_byte) || is_digit(cur_byte) || cur_byte == 8'h5F) begin
                    if (mode_reg == M_IDENT) begin
                        if (kw_reg[47:40] != 8'h00) begin
                            mode_next = M_IDENT_LONG;
                        end else begin
                            kw_next = {kw_reg[39:0], cur_byte};
                        end
                    end
                    consumed = 1'b1;
                end else begin
                    pend_emit     = 1'b1;
                    pend_tok.kind = (mode_reg == M_IDENT) ? kw_kind : K_IDENT;
                end
            end
            M_NUM: begin
                if (is_digit(cur_byte)) begin
                    consumed = 1'b1;
                end else if (cur_byte == CH_DOT) begin
                    mode_next = M_NUM_DOT;
                    consumed  = 1'b1;
                end else begin
                    pend_emit     = 1'b1;
                    pend_tok.kind = K_NUMBER;
                end
            end
            M_NUM_DOT: begin
                if (is_digit(cur_byte)) begin
                    consumed = 1'b1;
                end else begin
                    pend_emit     = 1'b1;
                    pend_tok.kind = K_FLOAT;
                end
            end
            M_STRING: begin
                pend_tok.kind = K_STRING;
                if (cur_byte == CH_QUOTE) begin
                    pend_emit = 1'b1;
                    mode_next = M_IDLE;
                    consumed  = 1'b1;
                end else if (cur_byte != CH_NUL) begin
                    consumed = 1'b1;
                end else begin
                    pend_emit = 1'b1;
                end
            end
            M_OP: begin
                pend_emit     = 1'b1;
                pend_tok.kind = K_OPER;
                if (cur_byte == CH_EQ) begin
                    pend_tok.length = 16'd2;
                    mode_next       = M_IDLE;
                    consumed        = 1'b1;
                end else begin
                    pend_tok.length = 16'd1;
                end
            end
            default: begin
            end
        endcase

        // the byte starts something new
        if (!consumed) begin
            mode_next = M_IDLE;
            kw_next   = '0;
            if (cur_byte == CH_NUL) begin
                new_emit     = 1'b1;
                new_tok.kind = K_END;
                start_next   = '0;
                off_next     = '0;
            end else if (is_space(cur_byte)) begin
                // skipped
            end else if (is_alpha(cur_byte) || cur_byte == 8'h5F) begin
                mode_next  = M_IDENT;
                start_next = off_reg;
                kw_next    = {40'h0, cur_byte};
            end else if (is_digit(cur_byte)) begin
                mode_next  = M_NUM;
                start_next = off_reg;
            end else if (cur_byte == CH_QUOTE) begin
                mode_next  = M_STRING;
                start_next = cur_inc;
            end else if (is_op(cur_byte)) begin
                if (is_op_pair(cur_byte)) begin
                    mode_next  = M_OP;
                    start_next = off_reg;
                end else begin
                    new_emit       = 1'b1;
                    new_tok.kind   = K_OPER;
                    new_tok.length = 16'd1;
                end
            end else if (is_sep(cur_byte)) begin
                new_emit       = 1'b1;
                new_tok.kind   = K_SEP;
                new_tok.length = 16'd1;
            end else begin
                new_emit = 1'b1;
            end
        end
    end

    // Pack results in order; the final one carries last
    always_comb begin
        emit.cnt  = {1'b0, pend_emit} + {1'b0, new_emit};
        emit.tok0 = pend_emit ? pend_tok : new_tok;
        emit.tok1 = new_tok;
        emit.tok0.last = !(pend_emit && new_emit);
        emit.tok1.last = 1'b1;
    end

    // Scanner state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= M_IDLE;
            off_reg   <= '0;
            start_reg <= '0;
            kw_reg    <= '0;
        end else if (step) begin
            mode_reg  <= mode_next;
            off_reg   <= off_next;
            start_reg <= start_next;
            kw_reg    <= kw_next;
        end
    end

endmodule

// ----- hw/rtl/stt_out_fifo.sv -----
// stt_out_fifo: four-entry result queue that takes up to two tokens per cycle
// and hands out one beat per cycle while out_ready is high.
// Depends on stt_pkg.
`timescale 1ns / 1ps

module stt_out_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,       // write emit.cnt entries
    input  stt_pkg::emit_t  emit,
    output logic            room,       // two free entries after this cycle's pop
    output logic            out_valid,
    input  logic            out_ready,
    output stt_pkg::token_t out_tok
);
    import stt_pkg::*;

    token_t     mem_reg [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg;
    logic [2:0] cnt_reg,    cnt_next;
    logic [1:0] wr_cnt;
    logic       pop;

    assign out_valid = cnt_reg != 3'd0;
    assign out_tok   = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign room      = (cnt_reg <= 3'd2) || (pop && cnt_reg == 3'd3);
    assign wr_cnt    = push ? emit.cnt : 2'd0;

    assign wr_ptr_next = wr_ptr_reg + wr_cnt;
    assign cnt_next    = cnt_reg + {1'b0, wr_cnt} - {2'b0, pop};

    // Storage
    always_ff @(posedge aclk) begin
        if (wr_cnt != 2'd0) begin
            mem_reg[wr_ptr_reg] <= emit.tok0;
        end
        if (wr_cnt == 2'd2) begin
            mem_reg[wr_ptr_reg + 2'd1] <= emit.tok1;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
        end
    end

endmodule

// ----- hw/rtl/source_text_tokenizer.sv -----
// Source text tokenizer.
// Input beats on s_* carry one source byte each; result beats on m_* carry one
// token each (kind, start offset, length), with m_tlast set on the final token
// caused by an input byte. A byte of value 0 ends the source: any open token is
// flushed, an end token follows, and the scanner returns to its reset state.
// Each byte is registered on acceptance and stepped through the scanner once the
// result queue has room; its tokens are written into the queue as it steps and
// are presented on m_* from the head of the queue.
// Throughput is one byte per cycle while m_tready stays high and bytes produce at
// most one token each; a byte that closes a token and starts another emits two
// beats, and the four-entry result queue absorbs these, so the output port (one
// beat per cycle) sets the long-run rate.
// When the receiver stalls, the queue fills and s_tready drops once the queue
// cannot take two more tokens; no token is lost or repeated.
// Reset (aresetn low, synchronous) empties the queue and input register and
// clears the offset counter and scanner state.
// Depends on stt_pkg, stt_lexer, stt_out_fifo.
`timescale 1ns / 1ps

module source_text_tokenizer #(
    parameter int OFFSET_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] source_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [3:0] token_kind, [19:4] token_start,
                                    // [35:20] token_length, [39:36] zero
    output logic        m_tlast     // last_of_run
);
    import stt_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       step;
    logic       room;
    emit_t      emit;
    token_t     out_tok;

    assign step     = in_valid_reg && room;
    assign s_tready = !in_valid_reg || step;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    stt_lexer #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_lexer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .cur_byte (in_byte_reg),
        .emit     (emit)
    );

    stt_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (step),
        .emit      (emit),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_tok   (out_tok)
    );

    // Result beat
    assign m_tdata = {4'h0, out_tok.length, out_tok.start, out_tok.kind};
    assign m_tlast = out_tok.last;

endmodule
